// ----- src/rmf_pkg.sv -----
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants for the rolling median filter
// Window size, sample and count types, and the item that moves along the
// chain of window cells.
// ----------------------------------------------------------------------------
package rmf_pkg;

	localparam int WINDOW   = 5;
	localparam int SAMPLE_W = 32;
	localparam int CNT_W    = $clog2(WINDOW + 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic    vld;
		sample_t smp;
	} cell_t;

endpackage

// ----- src/rmf_cell.sv -----
// ----------------------------------------------------------------------------
// rmf_cell: one window cell
// Holds one sample and its valid flag; takes its neighbor's content on every
// accepted item.
// ----------------------------------------------------------------------------
module rmf_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  rmf_pkg::cell_t prev,
	output rmf_pkg::cell_t held
);

	logic             vld_q;
	rmf_pkg::sample_t smp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= prev.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			smp_q <= prev.smp;
		end
	end

	assign held.vld = vld_q;
	assign held.smp = smp_q;

endmodule

// ----- src/rmf_select.sv -----
// ----------------------------------------------------------------------------
// rmf_select: rank and pick
// Ranks every valid lane against the others (ties ordered by lane) and
// picks the lane whose rank equals half the valid count.
// ----------------------------------------------------------------------------
module rmf_select (
	input  rmf_pkg::cell_t   lane [rmf_pkg::WINDOW],
	output rmf_pkg::sample_t median
);

	rmf_pkg::cnt_t rank [rmf_pkg::WINDOW];
	rmf_pkg::cnt_t cnt;
	rmf_pkg::cnt_t half;

	always_comb begin
		for (int i = 0; i < rmf_pkg::WINDOW; i++) begin
			rank[i] = '0;
			for (int j = 0; j < rmf_pkg::WINDOW; j++) begin
				if (j != i && lane[j].vld &&
				    (($signed(lane[j].smp) < $signed(lane[i].smp)) ||
				     (lane[j].smp == lane[i].smp && j < i))) begin
					rank[i] = rank[i] + rmf_pkg::cnt_t'(1);
				end
			end
		end
	end

	always_comb begin
		cnt = '0;
		for (int i = 0; i < rmf_pkg::WINDOW; i++) begin
			cnt = cnt + rmf_pkg::cnt_t'(lane[i].vld);
		end
		half = cnt >> 1;
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < rmf_pkg::WINDOW; i++) begin
			if (lane[i].vld && rank[i] == half) begin
				median = lane[i].smp;
			end
		end
	end

endmodule

// ----- src/rolling_median_of_five.sv -----
// ----------------------------------------------------------------------------
// rolling_median_of_five: running median over the last five samples
// A chain of cells holds the previous samples; each item's median is ranked
// over the new sample and the chain, then registered with a skid stage.
//
//   channel   valid          stall          payload
//   input     sample_valid   sample_stall   sample (32-bit signed)
//   output    median_valid   median_stall   median (32-bit signed)
//
// One item per cycle while sample_stall is low; the median is registered.
// The rank compare across the window and the new sample sets the path.
// Reset empties the window; until it fills only samples taken count.
// An output stall is absorbed by the skid register; sample_stall rises only
// when both output and skid registers hold items.
// ----------------------------------------------------------------------------
module rolling_median_of_five (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  logic signed [31:0]      sample,
	output logic                    median_valid,
	input  logic                    median_stall,
	output logic signed [31:0]      median
);

	rmf_pkg::cell_t   held [rmf_pkg::WINDOW-1];
	rmf_pkg::cell_t   lane [rmf_pkg::WINDOW];
	rmf_pkg::cell_t   head;
	rmf_pkg::sample_t med_nxt;

	logic             acc;
	logic             take;
	logic             median_valid_q;
	logic             skid_valid_q;
	rmf_pkg::sample_t median_q;
	rmf_pkg::sample_t skid_q;

	assign head.vld = 1'b1;
	assign head.smp = sample;

	assign acc  = sample_valid && !skid_valid_q;
	assign take = median_valid_q && !median_stall;

	for (genvar k = 0; k < rmf_pkg::WINDOW - 1; k++) begin : g_cell
		rmf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (acc),
			.prev    ((k == 0) ? head : held[(k == 0) ? 0 : k - 1]),
			.held    (held[k])
		);
	end

	always_comb begin
		lane[0] = head;
		for (int k = 1; k < rmf_pkg::WINDOW; k++) begin
			lane[k] = held[k-1];
		end
	end

	rmf_select u_select (
		.lane   (lane),
		.median (med_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			median_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!acc) begin
				median_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (!median_valid_q) begin
				median_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				median_q <= skid_q;
			end else if (acc) begin
				median_q <= med_nxt;
			end
		end else if (acc) begin
			if (!median_valid_q) begin
				median_q <= med_nxt;
			end else begin
				skid_q <= med_nxt;
			end
		end
	end

	assign sample_stall = skid_valid_q;
	assign median_valid = median_valid_q;
	assign median       = median_q;

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> median_valid_q)
		else $error("skid holds an item while output register is empty");

	a_chain_head: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (held[0].vld && held[0].smp == $past(sample)))
		else $error("accepted item not held in first cell");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(median_valid_q && median_stall))
		else $error("skid filled without a stalled output");
`endif

endmodule
